// File: hw/rtl/dlrs_pkg.sv
// Shared types and constants for the decimal radix sorter.
package dlrs_pkg;

	localparam int MAX_ITEMS_DEF  = 16;
	localparam int VALUE_BITS_DEF = 16;
	localparam int RADIX          = 10;
	localparam int DIGIT_W        = 4;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_COUNT,
		ST_PREFIX,
		ST_PLACE,
		ST_COPY,
		ST_EMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic clear_counts;
		logic count_en;
		logic prefix_en;
		logic place_en;
		logic copy_en;
		logic next_place;
		logic emit_en;
		logic restart;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic prefix_done;
		logic more_digits;
		logic emit_done;
	} status_t;

endpackage

// File: hw/rtl/dlrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module dlrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/dlrs_ctrl.sv
// Controller state machine of the decimal radix sorter.
module dlrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_last,
	input  logic                out_taken,
	input  dlrs_pkg::status_t   sts,
	output dlrs_pkg::cmd_t      cmd,
	output logic                load_ready,
	output dlrs_pkg::state_t    state
);

	dlrs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlrs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dlrs_pkg::ST_LOAD: begin
				if (load_last) begin
					state_d = sts.more_digits ? dlrs_pkg::ST_COUNT : dlrs_pkg::ST_EMIT;
				end
			end
			dlrs_pkg::ST_COUNT: begin
				if (sts.scan_done) state_d = dlrs_pkg::ST_PREFIX;
			end
			dlrs_pkg::ST_PREFIX: begin
				if (sts.prefix_done) state_d = dlrs_pkg::ST_PLACE;
			end
			dlrs_pkg::ST_PLACE: begin
				if (sts.scan_done) state_d = dlrs_pkg::ST_COPY;
			end
			dlrs_pkg::ST_COPY: begin
				if (sts.scan_done) begin
					state_d = sts.more_digits ? dlrs_pkg::ST_COUNT : dlrs_pkg::ST_EMIT;
				end
			end
			dlrs_pkg::ST_EMIT: begin
				if (out_taken && sts.emit_done) state_d = dlrs_pkg::ST_LOAD;
			end
			default: state_d = dlrs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		load_ready = 1'b0;
		case (state_q)
			dlrs_pkg::ST_LOAD: begin
				load_ready = 1'b1;
				cmd.clear_counts = 1'b1;
			end
			dlrs_pkg::ST_COUNT:  cmd.count_en = 1'b1;
			dlrs_pkg::ST_PREFIX: cmd.prefix_en = 1'b1;
			dlrs_pkg::ST_PLACE:  cmd.place_en = 1'b1;
			dlrs_pkg::ST_COPY: begin
				cmd.copy_en = 1'b1;
				cmd.clear_counts = sts.scan_done;
				cmd.next_place = sts.scan_done;
			end
			dlrs_pkg::ST_EMIT: begin
				cmd.emit_en = 1'b1;
				cmd.restart = out_taken && sts.emit_done;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: hw/rtl/dlrs_dp.sv
// Datapath: element store, pass buffer, digit counters and output register.
module dlrs_dp #(
	parameter int MAX_ITEMS  = dlrs_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = dlrs_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dlrs_pkg::cmd_t        cmd,
	input  logic                  load_en,
	input  logic                  load_last,
	input  logic [15:0]           load_value,
	input  logic                  out_taken,
	output dlrs_pkg::status_t     sts,
	output logic                  out_valid,
	output logic [15:0]           out_value,
	output logic                  out_last
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int VW = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int PW = VW + 4;

	// Scan phases: step 0 issues the read of the next index; a data-valid flag
	// tracks the registered read, which arrives in the cycle after the issue.
	logic [CW-1:0] count_q;
	logic [VW-1:0] largest_q;
	logic [PW-1:0] place_q;
	logic [CW-1:0] idx_q;
	logic          rd_vld_q;
	logic [CW-1:0] cnt_q [dlrs_pkg::RADIX];
	logic [dlrs_pkg::DIGIT_W-1:0] pfx_q;

	logic [VW-1:0] masked;
	logic          store_ok;
	assign masked   = load_value[VW-1:0];
	assign store_ok = load_en && (count_q < CW'(MAX_ITEMS));

	// Element store ports.
	logic          es_we;
	logic [AW-1:0] es_waddr, es_raddr;
	logic [VW-1:0] es_wdata, es_rdata;
	logic          pb_we;
	logic [AW-1:0] pb_waddr, pb_raddr;
	logic [VW-1:0] pb_wdata, pb_rdata;

	dlrs_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_store (
		.clk(clk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
		.raddr(es_raddr), .rdata(es_rdata)
	);
	dlrs_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_buf (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
		.raddr(pb_raddr), .rdata(pb_rdata)
	);

	// Digit of the read element: hold the element, divide its copy by ten once
	// per cycle for each digit place below the current one, then take mod 10.
	logic [VW-1:0] quo_q;
	logic [VW-1:0] held_q;
	logic [2:0]    div_step_q;
	logic          div_busy_q;
	logic [dlrs_pkg::DIGIT_W-1:0] digit_q;
	logic          digit_vld_q;
	logic [2:0]    place_exp_q;

	// Divide by ten: one step per cycle, place_exp_q steps, then take mod 10.
	function automatic logic [VW-1:0] div10(input logic [VW-1:0] v);
		logic [VW+19:0] p;
		p = ({20'd0, v} * (VW+20)'(20'hCCCCD)) >> 23;
		return p[VW-1:0];
	endfunction

	logic [VW-1:0] q10;
	logic [dlrs_pkg::DIGIT_W-1:0] rem10;
	logic [VW+3:0] q10x;
	assign q10   = div10(quo_q);
	assign q10x  = {4'd0, q10} * (VW+4)'(10);
	assign rem10 = dlrs_pkg::DIGIT_W'(quo_q - q10x[VW-1:0]);

	logic phase_scan;
	assign phase_scan = cmd.count_en || cmd.place_en || cmd.copy_en;

	logic issue;
	assign issue = phase_scan && !rd_vld_q && !div_busy_q && !digit_vld_q
		&& (idx_q < count_q);

	logic [AW-1:0] idx_rd;
	always_comb begin
		if (cmd.place_en) idx_rd = AW'(count_q - idx_q - CW'(1));
		else idx_rd = idx_q[AW-1:0];
	end

	assign es_raddr = idx_rd;
	assign pb_raddr = cmd.emit_en ? idx_q[AW-1:0] : idx_q[AW-1:0];

	logic [dlrs_pkg::DIGIT_W-1:0] d;
	assign d = digit_q;
	logic [CW-1:0] slot;
	assign slot = cnt_q[d] - CW'(1);

	always_comb begin
		es_we = 1'b0; es_waddr = count_q[AW-1:0]; es_wdata = masked;
		pb_we = 1'b0; pb_waddr = slot[AW-1:0]; pb_wdata = held_q;
		if (store_ok) es_we = 1'b1;
		if (cmd.copy_en && rd_vld_q) begin
			es_we = 1'b1; es_waddr = AW'(idx_q - CW'(1)); es_wdata = pb_rdata;
		end
		if (cmd.place_en && digit_vld_q && cnt_q[d] != '0) pb_we = 1'b1;
	end

	logic [PW-1:0] next_place;
	assign next_place = (place_q << 3) + (place_q << 1);

	assign sts.scan_done = phase_scan && (idx_q >= count_q) && !rd_vld_q
		&& !div_busy_q && !digit_vld_q;
	assign sts.prefix_done = (pfx_q == dlrs_pkg::DIGIT_W'(dlrs_pkg::RADIX - 1));
	assign sts.more_digits = cmd.next_place
		? (PW'(largest_q) >= next_place)
		: ((load_en && load_last) ? ((store_ok && masked != '0) || largest_q != '0)
			: 1'b0);
	assign sts.emit_done = (idx_q + CW'(1) >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; largest_q <= '0; place_q <= PW'(1); idx_q <= '0;
			rd_vld_q <= 1'b0; pfx_q <= '0; div_busy_q <= 1'b0; div_step_q <= '0;
			digit_vld_q <= 1'b0; place_exp_q <= '0; out_valid <= 1'b0;
			quo_q <= '0; held_q <= '0; digit_q <= '0;
			out_value <= '0; out_last <= 1'b0;
			for (int k = 0; k < dlrs_pkg::RADIX; k++) cnt_q[k] <= '0;
		end else begin
			if (store_ok) begin
				count_q <= count_q + CW'(1);
				if (masked > largest_q) largest_q <= masked;
			end
			if (cmd.clear_counts) begin
				for (int k = 0; k < dlrs_pkg::RADIX; k++) cnt_q[k] <= '0;
				pfx_q <= '0;
				idx_q <= '0;
			end
			if (cmd.next_place) begin
				place_q <= next_place;
				place_exp_q <= place_exp_q + 3'd1;
			end
			if (issue) begin
				idx_q <= idx_q + CW'(1);
				rd_vld_q <= 1'b1;
			end else begin
				rd_vld_q <= 1'b0;
			end
			// Start digit extraction on count and place reads.
			if (rd_vld_q && (cmd.count_en || cmd.place_en)) begin
				quo_q <= es_rdata;
				held_q <= es_rdata;
				div_step_q <= place_exp_q;
				div_busy_q <= 1'b1;
			end
			if (div_busy_q) begin
				if (div_step_q == '0) begin
					digit_q <= rem10;
					digit_vld_q <= 1'b1;
					div_busy_q <= 1'b0;
				end else begin
					quo_q <= q10;
					div_step_q <= div_step_q - 3'd1;
				end
			end
			if (digit_vld_q) begin
				digit_vld_q <= 1'b0;
				if (cmd.count_en) cnt_q[d] <= cnt_q[d] + CW'(1);
				if (cmd.place_en && cnt_q[d] != '0) cnt_q[d] <= slot;
			end
			if (cmd.prefix_en && !sts.prefix_done) begin
				cnt_q[pfx_q + 1'b1] <= cnt_q[pfx_q + 1'b1] + cnt_q[pfx_q];
				pfx_q <= pfx_q + 1'b1;
			end
			if (cmd.prefix_en && sts.prefix_done) idx_q <= '0;
			if (cmd.place_en && sts.scan_done) idx_q <= '0;
			// Emission: read store at idx, present in output register.
			if (cmd.emit_en) begin
				if (!out_valid && !rd_vld_q) begin
					rd_vld_q <= 1'b1;
				end else if (rd_vld_q) begin
					out_valid <= 1'b1;
					out_value <= 16'(es_rdata);
					out_last <= sts.emit_done;
				end else if (out_taken) begin
					out_valid <= 1'b0;
					idx_q <= idx_q + CW'(1);
				end
			end
			if (cmd.restart) begin
				count_q <= '0; largest_q <= '0; place_q <= PW'(1); place_exp_q <= '0;
				idx_q <= '0;
			end
		end
	end

	property p_no_overfill;
		@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_ITEMS);
	endproperty
	a_no_overfill: assert property (p_no_overfill) else $error("element count overflow");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.count_en, cmd.place_en, cmd.copy_en, cmd.emit_en, load_en}))
		else $error("overlapping phases");

	a_slot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.place_en && digit_vld_q) |-> (cnt_q[d] != '0))
		else $error("placement slot underflow");

endmodule

// File: hw/rtl/decimal_lsd_radix_sorter.sv
// Top level of the decimal least-significant-digit radix sorter.
// Loads one value per transfer until tlast, then sorts and streams the set out in
// ascending order with tlast on the final value. Each decimal digit of the largest
// value then costs a count scan and a placement scan, in which the quotient of each
// element is reduced by ten once per cycle down to the current digit position; a
// prefix step over the ten counters; and a copy scan. Each scan finishes one element
// before it reads the next. Emission waits while m_tready is held low.
// No input is taken while a set is sorted or emitted.
module decimal_lsd_radix_sorter #(
	parameter int MAX_ITEMS  = dlrs_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = dlrs_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // value
	input  logic        s_tlast,  // final_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // sorted_value
	output logic        m_tlast   // final_result
);

	dlrs_pkg::cmd_t    cmd;
	dlrs_pkg::status_t sts;
	dlrs_pkg::state_t  state;
	logic load_ready, load_en, out_taken;

	assign s_tready  = load_ready;
	assign load_en   = s_tvalid && load_ready;
	assign out_taken = m_tvalid && m_tready;

	dlrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .load_last(load_en && s_tlast),
		.out_taken(out_taken), .sts(sts), .cmd(cmd), .load_ready(load_ready),
		.state(state)
	);

	dlrs_dp #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .load_en(load_en),
		.load_last(s_tlast), .load_value(s_tdata), .out_taken(out_taken),
		.sts(sts), .out_valid(m_tvalid), .out_value(m_tdata), .out_last(m_tlast)
	);

	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state == dlrs_pkg::ST_EMIT) |-> !s_tready)
		else $error("load accepted during emission");

	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state == dlrs_pkg::ST_EMIT))
		else $error("output outside emission");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_taken && m_tlast) |=> (state == dlrs_pkg::ST_LOAD))
		else $error("set did not end after last result");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the decimal radix sorter: directed table, random sets, then a receiver hold-off.
module tb;
	localparam int SET_CAP = 16;

	typedef struct {
		logic [15:0] value;
		logic        final_item;
		logic        has_exp;
		logic [15:0] exp_value;
	} row_t;

	typedef struct {
		logic [15:0] sorted_value;
		logic        final_result;
	} sorted_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	decimal_lsd_radix_sorter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [15:0] held_values[$];
	sorted_t     sorted_queue[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off = 0;
	bit          done_sending = 0;
	row_t        rows[$];

	// Stable digit-by-digit sort of the held set; pushes expected results.
	task automatic sort_and_queue();
		logic [15:0] vals[$];
		logic [15:0] buckets[10][$];
		logic [15:0] top;
		int unsigned place;
		sorted_t r;
		vals = held_values;
		top = 0;
		foreach (vals[i]) if (vals[i] > top) top = vals[i];
		for (place = 1; top / place > 0; place *= 10) begin
			for (int d = 0; d < 10; d++) buckets[d].delete();
			foreach (vals[i]) buckets[(vals[i] / place) % 10].push_back(vals[i]);
			vals.delete();
			for (int d = 0; d < 10; d++) foreach (buckets[d][j]) vals.push_back(buckets[d][j]);
		end
		foreach (vals[i]) begin
			r.sorted_value = vals[i];
			r.final_result = (i == vals.size() - 1);
			sorted_queue.push_back(r);
		end
		held_values.delete();
	endtask

	task automatic predict_load(logic [15:0] v, logic last);
		if (held_values.size() < SET_CAP) held_values.push_back(v);
		if (last) sort_and_queue();
	endtask

	// drive one transfer; predict on acceptance; tvalid stays high afterwards
	task automatic send_item(logic [15:0] v, logic last);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= v;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_load(v, last);
	endtask

	// back-to-back sends keep tvalid high: only lower it when idling
	task automatic send_set(int n, int style);
		logic [15:0] v;
		for (int i = 0; i < n; i++) begin
			case (style)
				0: v = 16'($urandom_range(65535));
				1: v = 16'($urandom_range(9));
				2: v = 16'($urandom_range(999));
				default: v = ($urandom_range(1)) ? 16'hFFFF : 16'd0;
			endcase
			send_item(v, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (sorted_queue.size() != 0) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (sorted_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %0d", m_tdata);
				end else begin
					if (m_tdata !== sorted_queue[0].sorted_value ||
					    m_tlast !== sorted_queue[0].final_result) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %0d/%0b got %0d/%0b",
								sorted_queue[0].sorted_value, sorted_queue[0].final_result,
								m_tdata, m_tlast);
					end
					void'(sorted_queue.pop_front());
				end
			end
			m_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || done_sending || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic row_t mk(logic [15:0] v, logic l, logic he, logic [15:0] ev);
		row_t r;
		r.value = v; r.final_item = l; r.has_exp = he; r.exp_value = ev;
		return r;
	endfunction

	initial begin
		int wait_ctr;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		m_tready <= 1;
		// directed: single values, extremes, all zero, one digit, descending, store full
		rows.push_back(mk(16'd0, 1'b1, 1'b1, 16'd0));
		rows.push_back(mk(16'hFFFF, 1'b1, 1'b1, 16'hFFFF));
		rows.push_back(mk(16'd0, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'd0, 1'b1, 1'b0, 16'd0));
		rows.push_back(mk(16'd7, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'd3, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'd9, 1'b1, 1'b0, 16'd0));
		rows.push_back(mk(16'd65535, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'd10000, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'd1, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'd0, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'h5555, 1'b0, 1'b0, 16'd0));
		rows.push_back(mk(16'hAAAA, 1'b1, 1'b0, 16'd0));
		for (int i = 0; i < 17; i++)
			rows.push_back(mk(16'(20 - i), i == 16, 1'b0, 16'd0)); // last one dropped
		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				send_item(rows[i].value, rows[i].final_item);
				if (sorted_queue.size() != 0 && sorted_queue[$].sorted_value !== rows[i].exp_value) begin
					fail_count++;
					$display("directed row %0d predictor disagrees", i);
				end
			end else send_item(rows[i].value, rows[i].final_item);
		end
		wait_drained();
		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 32) : 0;
			recv_stall_pct = (ph == 2) ? 61 : ((ph == 3) ? 32 : 0);
			for (int s = 0; s < 16; s++)
				send_set($urandom_range(1, (s % 4 == 0) ? 18 : 9), $urandom_range(3));
		end
		// long receiver hold-off while the sender keeps offering
		send_idle_pct = 0; recv_stall_pct = 0;
		fork
			begin
				hold_off = 1;
				for (wait_ctr = 0; wait_ctr < 3000; wait_ctr++) @(posedge clk);
				hold_off = 0;
			end
			for (int s = 0; s < 4; s++) send_set(8, 0);
		join
		wait_drained();
		done_sending = 1;
		repeat (200) @(posedge clk);
		if (fail_count == 0 && sorted_queue.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
